// ===== rtl/pulse_rate_counter_defines.svh =====
// assertion macros for the pulse rate counter
`ifndef PULSE_RATE_COUNTER_DEFINES_SVH
`define PULSE_RATE_COUNTER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PRC_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define PRC_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/prc_pkg.sv =====
// shared constants, types and helpers for the pulse rate counter
`timescale 1ns / 1ps
`default_nettype none
package prc_pkg;

   // widths
   localparam int CNT_W     = 32;
   localparam int DATA_W    = 32;
   localparam int MULT_W    = 16;
   localparam int PROD_W    = 2 * DATA_W;
   localparam int FRAC_BITS = 8;
   localparam int REG_IDX_W = 2;
   localparam int MODE_W    = 2;

   localparam logic [DATA_W-1:0] SAT32      = '1;
   localparam logic [DATA_W-1:0] TPS_RESET  = 32'd1000000;
   localparam logic [MULT_W-1:0] MULT_RESET = 16'd256;

   // item kinds
   localparam logic FUNC_TICK = 1'b0;
   localparam logic FUNC_READ = 1'b1;

   // edge modes, anything else counts both edges
   localparam logic [MODE_W-1:0] EDGE_RISE = 2'd0;
   localparam logic [MODE_W-1:0] EDGE_FALL = 2'd1;

   // register indexes
   typedef enum logic [REG_IDX_W-1:0] {
      REG_EDGE_MODE  = 2'd0,
      REG_MULTIPLIER = 2'd1,
      REG_TICKS_PER_SEC = 2'd2
   } reg_index_type;

   // controller to datapath
   typedef struct packed {
      logic tick;
      logic read;
      logic mul;
      logic chk;
      logic div_start;
      logic div_take;
      logic scale;
      logic load_out;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic elapsed_zero;
      logic rate_ovf;
      logic div_done;
   } status_type;

   // (x * Q8.8 factor) >> 8, saturated to 32 bits
   function automatic logic [DATA_W-1:0] scale_q88(input logic [DATA_W-1:0] x,
                                                   input logic [MULT_W-1:0] f);
      logic [DATA_W+MULT_W-1:0] p;
      p = (DATA_W+MULT_W)'(x) * (DATA_W+MULT_W)'(f);
      if (p[DATA_W+MULT_W-1:DATA_W+FRAC_BITS] != '0) begin
         return SAT32;
      end
      return p[DATA_W+FRAC_BITS-1:FRAC_BITS];
   endfunction

endpackage
`default_nettype wire

// ===== rtl/prc_if.sv =====
// request and response channel interfaces
`timescale 1ns / 1ps
`default_nettype none
interface prc_req_if;
   logic valid;
   logic ready;
   logic func;
   logic pin_level;
   modport source (output valid, func, pin_level, input ready);
   modport sink (input valid, func, pin_level, output ready);
endinterface

interface prc_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] pulses_seen;
   logic [31:0] pulses_scaled;
   logic [31:0] pulse_rate;
   logic [31:0] rate_scaled;
   logic        rate_valid;
   modport source (output valid, pulses_seen, pulses_scaled, pulse_rate, rate_scaled,
                   rate_valid, input ready);
   modport sink (input valid, pulses_seen, pulses_scaled, pulse_rate, rate_scaled,
                 rate_valid, output ready);
endinterface
`default_nettype wire

// ===== rtl/prc_div.sv =====
// iterative restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module prc_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [prc_pkg::DATA_W-1:0]  rem_init,
   input  logic [prc_pkg::DATA_W-1:0]  bits_init,
   input  logic [prc_pkg::DATA_W-1:0]  divisor,
   output logic [prc_pkg::DATA_W-1:0]  quotient,
   output logic                        done
);
   localparam int CNT_BITS = $clog2(prc_pkg::DATA_W);

   logic [prc_pkg::DATA_W-1:0] rem_ff;
   logic [prc_pkg::DATA_W-1:0] rem_in;
   logic [prc_pkg::DATA_W-1:0] sh_ff;
   logic [prc_pkg::DATA_W-1:0] div_ff;
   logic [CNT_BITS-1:0]        cnt_ff;
   logic                       busy_ff;
   logic                       done_ff;
   logic [prc_pkg::DATA_W:0]   trial;
   logic                       q_bit;

   // one trial subtract per cycle, remainder stays below the divisor
   always_comb begin
      trial = {rem_ff, sh_ff[prc_pkg::DATA_W-1]};
      q_bit = trial >= {1'b0, div_ff};
      if (q_bit) begin
         rem_in = prc_pkg::DATA_W'(trial - {1'b0, div_ff});
      end else begin
         rem_in = trial[prc_pkg::DATA_W-1:0];
      end
   end

   // control: busy flag, step count, done pulse
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_BITS'(prc_pkg::DATA_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // dividend bits shift out as quotient bits shift in
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= rem_init;
         sh_ff  <= bits_init;
         div_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         sh_ff  <= {sh_ff[prc_pkg::DATA_W-2:0], q_bit};
      end
   end

   assign quotient = sh_ff;
   assign done     = done_ff;
endmodule
`default_nettype wire

// ===== rtl/prc_datapath.sv =====
// edge counting, config registers and rate arithmetic
`timescale 1ns / 1ps
`default_nettype none
module prc_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  prc_pkg::cmd_type                cmd,
   output prc_pkg::status_type             status,
   input  logic                            req_pin_level,
   input  logic                            csr_we,
   input  logic [prc_pkg::REG_IDX_W-1:0]   csr_index,
   input  logic [prc_pkg::DATA_W-1:0]      csr_wdata,
   output logic [prc_pkg::DATA_W-1:0]      rsp_pulses_seen,
   output logic [prc_pkg::DATA_W-1:0]      rsp_pulses_scaled,
   output logic [prc_pkg::DATA_W-1:0]      rsp_pulse_rate,
   output logic [prc_pkg::DATA_W-1:0]      rsp_rate_scaled,
   output logic                            rsp_rate_valid
);
   localparam int DW = prc_pkg::DATA_W;
   localparam int PW = prc_pkg::PROD_W;
   localparam int FB = prc_pkg::FRAC_BITS;

   // configuration
   logic [prc_pkg::MODE_W-1:0] edge_mode_ff;
   logic [prc_pkg::MULT_W-1:0] mult_ff;
   logic [DW-1:0]              tps_ff;

   // counting state
   logic                       prev_ff;
   logic [prc_pkg::CNT_W-1:0]  edge_cnt_ff;
   logic [prc_pkg::CNT_W-1:0]  last_cnt_ff;
   logic [DW-1:0]              elapsed_ff;

   // read working registers
   logic [DW-1:0] pulses_ff;
   logic [DW-1:0] pulses_in;
   logic [DW-1:0] elapsed_snap_ff;
   logic [PW-1:0] prod_ff;
   logic [PW-1:0] prod_in;
   logic [DW-1:0] pscaled_ff;
   logic [DW-1:0] rate_ff;
   logic          rvalid_ff;
   logic [DW-1:0] rscaled_ff;

   // output register
   logic [DW-1:0] out_pulses_ff;
   logic [DW-1:0] out_pscaled_ff;
   logic [DW-1:0] out_rate_ff;
   logic [DW-1:0] out_rscaled_ff;
   logic          out_rvalid_ff;

   logic                      hit;
   logic [prc_pkg::CNT_W-1:0] cnt_diff;
   logic [63:0]               diff_wide;
   logic [DW-1:0]             quotient;
   logic                      div_done;

   // edge detect per mode
   always_comb begin
      case (edge_mode_ff)
         prc_pkg::EDGE_RISE: hit = !prev_ff && req_pin_level;
         prc_pkg::EDGE_FALL: hit = prev_ff && !req_pin_level;
         default:            hit = prev_ff != req_pin_level;
      endcase
   end

   // pulses since last read, modular; the 32-bit difference never reaches the saturation clamp
   assign cnt_diff  = edge_cnt_ff - last_cnt_ff;
   assign diff_wide = 64'(cnt_diff);
   assign pulses_in = (diff_wide > 64'(prc_pkg::SAT32)) ? prc_pkg::SAT32 : diff_wide[DW-1:0];

   // pulses times ticks per second
   assign prod_in = PW'(pulses_ff) * PW'(tps_ff);

   // status toward the controller
   assign status.elapsed_zero = elapsed_snap_ff == '0;
   assign status.rate_ovf     = prod_ff[PW-1:PW-DW-FB] >= (DW+FB)'(elapsed_snap_ff);
   assign status.div_done     = div_done;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         edge_mode_ff <= prc_pkg::EDGE_RISE;
         mult_ff      <= prc_pkg::MULT_RESET;
         tps_ff       <= prc_pkg::TPS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            prc_pkg::REG_EDGE_MODE:     edge_mode_ff <= csr_wdata[prc_pkg::MODE_W-1:0];
            prc_pkg::REG_MULTIPLIER:    mult_ff      <= csr_wdata[prc_pkg::MULT_W-1:0];
            prc_pkg::REG_TICKS_PER_SEC: tps_ff       <= csr_wdata;
            default: ;
         endcase
      end
   end

   // tick and read update of the counters
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff     <= 1'b0;
         edge_cnt_ff <= '0;
         last_cnt_ff <= '0;
         elapsed_ff  <= '0;
      end else if (cmd.tick) begin
         prev_ff <= req_pin_level;
         if (hit) begin
            edge_cnt_ff <= edge_cnt_ff + 1'b1;
         end
         if (elapsed_ff != prc_pkg::SAT32) begin
            elapsed_ff <= elapsed_ff + 1'b1;
         end
      end else if (cmd.read) begin
         last_cnt_ff <= edge_cnt_ff;
         elapsed_ff  <= '0;
      end
   end

   // read computation steps
   always_ff @(posedge clock) begin
      if (cmd.read) begin
         pulses_ff       <= pulses_in;
         elapsed_snap_ff <= elapsed_ff;
      end
      if (cmd.mul) begin
         prod_ff    <= prod_in;
         pscaled_ff <= prc_pkg::scale_q88(pulses_ff, mult_ff);
      end
      if (cmd.chk) begin
         if (status.elapsed_zero) begin
            rate_ff   <= '0;
            rvalid_ff <= 1'b0;
         end else if (status.rate_ovf) begin
            rate_ff   <= prc_pkg::SAT32;
            rvalid_ff <= 1'b1;
         end
      end
      if (cmd.div_take) begin
         rate_ff   <= quotient;
         rvalid_ff <= 1'b1;
      end
      if (cmd.scale) begin
         rscaled_ff <= prc_pkg::scale_q88(rate_ff, mult_ff);
      end
      if (cmd.load_out) begin
         out_pulses_ff  <= pulses_ff;
         out_pscaled_ff <= pscaled_ff;
         out_rate_ff    <= rate_ff;
         out_rscaled_ff <= rscaled_ff;
         out_rvalid_ff  <= rvalid_ff;
      end
   end

   // floor(prod * 256 / elapsed), known to fit 32 bits here
   prc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .rem_init  (prod_ff[PW-FB-1:DW-FB]),
      .bits_init ({prod_ff[DW-FB-1:0], FB'(0)}),
      .divisor   (elapsed_snap_ff),
      .quotient  (quotient),
      .done      (div_done)
   );

   assign rsp_pulses_seen   = out_pulses_ff;
   assign rsp_pulses_scaled = out_pscaled_ff;
   assign rsp_pulse_rate    = out_rate_ff;
   assign rsp_rate_scaled   = out_rscaled_ff;
   assign rsp_rate_valid    = out_rvalid_ff;
endmodule
`default_nettype wire

// ===== rtl/prc_ctrl.sv =====
// sequencer for tick and read items and the response handshake
`timescale 1ns / 1ps
`default_nettype none
module prc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_func,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  prc_pkg::status_type  status,
   output prc_pkg::cmd_type     cmd
);
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_CHK,
      ST_DIV,
      ST_SCALE,
      ST_DONE
   } state_type;

   state_type state_ff;
   logic      out_valid_ff;
   logic      accept;

   // command decode
   always_comb begin
      accept        = req_valid && (state_ff == ST_IDLE);
      cmd.tick      = accept && (req_func == prc_pkg::FUNC_TICK);
      cmd.read      = accept && (req_func == prc_pkg::FUNC_READ);
      cmd.mul       = state_ff == ST_MUL;
      cmd.chk       = state_ff == ST_CHK;
      cmd.div_start = (state_ff == ST_CHK) && !status.elapsed_zero && !status.rate_ovf;
      cmd.div_take  = (state_ff == ST_DIV) && status.div_done;
      cmd.scale     = state_ff == ST_SCALE;
      cmd.load_out  = (state_ff == ST_DONE) && (!out_valid_ff || rsp_ready);
   end

   // state and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd.load_out) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (cmd.read) begin
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: state_ff <= ST_CHK;
            ST_CHK: begin
               if (cmd.div_start) begin
                  state_ff <= ST_DIV;
               end else begin
                  state_ff <= ST_SCALE;
               end
            end
            ST_DIV: begin
               if (cmd.div_take) begin
                  state_ff <= ST_SCALE;
               end
            end
            ST_SCALE: state_ff <= ST_DONE;
            ST_DONE: begin
               if (cmd.load_out) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_ready = state_ff == ST_IDLE;
   assign rsp_valid = out_valid_ff;
endmodule
`default_nettype wire

// ===== rtl/pulse_rate_counter.sv =====
// pulse rate counter top level: tick items are taken back to back while the sequencer is idle
// a read item holds the request side through the multiply, check, 32-step divide, scale and done states
// a read with zero elapsed time or a saturated rate skips the divider, going from check straight to scale
// the result sits in an output register, so ticks are taken while it waits
// synchronous reset clears config to defaults, counters to zero and the channels to idle
`timescale 1ns / 1ps
`default_nettype none
`include "pulse_rate_counter_defines.svh"
module pulse_rate_counter (
   input  logic                           clock,
   input  logic                           reset,
   prc_req_if.sink                        req_chan,
   prc_rsp_if.source                      rsp_chan,
   input  logic                           csr_we,
   input  logic [prc_pkg::REG_IDX_W-1:0]  csr_index,
   input  logic [prc_pkg::DATA_W-1:0]     csr_wdata
);
   prc_pkg::cmd_type    cmd;
   prc_pkg::status_type status;

   // sequencer
   prc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_func  (req_chan.func),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // counters and arithmetic
   prc_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_pin_level     (req_chan.pin_level),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_pulses_seen   (rsp_chan.pulses_seen),
      .rsp_pulses_scaled (rsp_chan.pulses_scaled),
      .rsp_pulse_rate    (rsp_chan.pulse_rate),
      .rsp_rate_scaled   (rsp_chan.rate_scaled),
      .rsp_rate_valid    (rsp_chan.rate_valid)
   );

   // checks
   `PRC_ASSERT_NXT(a_read_blocks, req_chan.valid && req_chan.ready && (req_chan.func == prc_pkg::FUNC_READ), !req_chan.ready, "read transfer did not start computation")
   `PRC_ASSERT_NXT(a_load_shows, cmd.load_out, rsp_chan.valid, "loaded result not presented")
   `PRC_ASSERT_IMP(a_cmd_excl, 1'b1, $onehot0({cmd.tick, cmd.read, cmd.mul, cmd.chk, cmd.div_take, cmd.scale, cmd.load_out}), "overlapping datapath commands")
   `PRC_ASSERT_IMP(a_zero_rate, rsp_chan.valid && !rsp_chan.rate_valid, (rsp_chan.pulse_rate == '0) && (rsp_chan.rate_scaled == '0), "invalid rate is not zero")
endmodule
`default_nettype wire
